[rtl/lmc_pkg.sv]
// lmc_pkg: types and constants for the led matrix chain frame controller
// no dependencies; imported by every rtl module of the block

package lmc_pkg;

  localparam int MAX_MODULES = 8;
  localparam int STORE_DEPTH = MAX_MODULES * 8;

  localparam logic [2:0] KIND_DOT   = 3'd0;
  localparam logic [2:0] KIND_ROW   = 3'd1;
  localparam logic [2:0] KIND_REG   = 3'd2;
  localparam logic [2:0] KIND_SHIFT = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  localparam logic [7:0] LEFT_BIT = 8'h80;
  localparam logic [2:0] LAST_ROW = 3'd7;
  localparam logic [2:0] LAST_MOD = 3'(MAX_MODULES - 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] column;
    logic [2:0] row;
    logic [7:0] value;
    logic [3:0] reg_address;
    logic       rotate;
  } in_t;

  typedef struct packed {
    logic [7:0] addr_byte;
    logic [7:0] data_byte;
    logic       latch_after;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] column;
    logic [2:0] row;
    logic [7:0] value;
    logic [3:0] reg_address;
    logic       rotate;
    logic [2:0] last_mod;
  } cmd_t;

endpackage

[rtl/led_matrix_chain_frame_controller.sv]
// led_matrix_chain_frame_controller: top level of the led matrix chain driver
// depends on lmc_pkg, lmc_front, lmc_queue, lmc_back
//
// channel   | direction | handshake                 | word
// command   | in        | start, busy               | cmd (in_t)
// result    | out       | result_strobe, no stall   | result (out_t)
// config    | in        | cfg_valid, cfg_ready      | cfg_data (module count)
//
// a command is taken when start is high and busy low; busy rises when the
// two-entry queue is full. the back end runs one command at a time: a set
// dot reads and rewrites its frame store entry before its words go out, and a
// shift handles one frame store entry per cycle, all 64 entries.
// results are registered and appear in the cycle after they are formed; the receiver cannot stall.
// reset clears the frame store valid bits at once, no clearing pass.

module led_matrix_chain_frame_controller import lmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_t        cmd,
  output logic       result_strobe,
  output out_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  logic push, full, avail, pop;
  cmd_t push_data, pop_data;

  assign busy = full;

  lmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (start && !busy),
    .cmd       (cmd),
    .push      (push),
    .push_data (push_data)
  );

  lmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .avail     (avail),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  lmc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .avail         (avail),
    .pop_data      (pop_data),
    .pop           (pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

[rtl/lmc_front.sv]
// lmc_front: module count register and command classification
// depends on lmc_pkg; feeds lmc_queue

module lmc_front import lmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  input  logic       accept,
  input  in_t        cmd,
  output logic       push,
  output cmd_t       push_data
);

  logic [3:0] module_count;
  logic [2:0] last_mod;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_count <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      module_count <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // clamp to 1..MAX_MODULES, kept as index of the last module
  always_comb begin
    if (module_count == 4'd0) begin
      last_mod = 3'd0;
    end else if (module_count > 4'(MAX_MODULES)) begin
      last_mod = LAST_MOD;
    end else begin
      last_mod = 3'(module_count - 4'd1);
    end
  end

  always_comb begin
    push_data.kind        = cmd.kind;
    push_data.column      = cmd.column;
    push_data.row         = cmd.row;
    push_data.value       = cmd.value;
    push_data.reg_address = cmd.reg_address;
    push_data.rotate      = cmd.rotate;
    push_data.last_mod    = last_mod;
    case (cmd.kind)
      KIND_DOT, KIND_ROW, KIND_REG, KIND_SHIFT, KIND_CLEAR: push = accept;
      default: push = 1'b0;
    endcase
  end

endmodule

[rtl/lmc_queue.sv]
// lmc_queue: two-entry command queue between front and back
// depends on lmc_pkg

module lmc_queue import lmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  output logic avail,
  input  logic pop,
  output cmd_t pop_data
);

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= !wptr;
      end
      if (pop && avail) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push && !full) - 2'(pop && avail);
    end
  end

  assign full     = (count == 2'd2);
  assign avail    = (count != 2'd0);
  assign pop_data = slots[rptr];

endmodule

[rtl/lmc_back.sv]
// lmc_back: frame store and word sequencer that carries out commands
// depends on lmc_pkg; takes commands from lmc_queue

module lmc_back import lmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic avail,
  input  cmd_t pop_data,
  output logic pop,
  output logic result_strobe,
  output out_t result
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DOT_WR = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;
  logic [7:0]             rd0, rd1;
  logic                   rv0, rv1;
  logic [7:0]             d0, d1;

  logic [1:0] state, state_next;
  cmd_t       cur, cur_next;
  logic [2:0] ci, ci_next, cj, cj_next;
  logic       wrap, wrap_next;
  logic [7:0] dot_byte, dot_next;

  logic [5:0] a0, a1, waddr;
  logic [7:0] wdata, mask, nb;
  logic       we, clr, emit, jl, wb;
  out_t       word;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[a0];
    rd1 <= mem[a1];
    rv0 <= valid[a0];
    rv1 <= valid[a1];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  assign d0 = rv0 ? rd0 : 8'd0;
  assign d1 = rv1 ? rd1 : 8'd0;

  always_comb begin
    state_next = state;
    cur_next   = cur;
    ci_next    = ci;
    cj_next    = cj;
    wrap_next  = wrap;
    dot_next   = dot_byte;
    a0         = '0;
    a1         = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    clr        = 1'b0;
    emit       = 1'b0;
    pop        = 1'b0;
    word       = '0;
    jl         = (cj == cur.last_mod);
    mask       = LEFT_BIT >> cur.column[2:0];
    nb         = '0;
    wb         = 1'b0;
    case (state)
      S_IDLE: begin
        if (avail) begin
          pop      = 1'b1;
          cur_next = pop_data;
          ci_next  = '0;
          cj_next  = '0;
          case (pop_data.kind)
            KIND_DOT: begin
              a0         = {pop_data.column[5:3], pop_data.row};
              state_next = S_DOT_WR;
            end
            KIND_SHIFT: begin
              a0         = {3'd0, 3'd0};
              a1         = {3'd1, 3'd0};
              state_next = S_SHIFT;
            end
            KIND_CLEAR: begin
              clr        = 1'b1;
              state_next = S_EMIT;
            end
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_DOT_WR: begin
        nb         = cur.value[0] ? (d0 | mask) : (d0 & ~mask);
        we         = 1'b1;
        waddr      = {cur.column[5:3], cur.row};
        wdata      = nb;
        dot_next   = nb;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        emit             = 1'b1;
        word.latch_after = jl;
        case (cur.kind)
          KIND_DOT: begin
            if (cj == cur.column[5:3]) begin
              word.addr_byte = {5'd0, cur.row} + 8'd1;
              word.data_byte = dot_byte;
            end
            word.last = jl;
          end
          KIND_ROW: begin
            we             = 1'b1;
            waddr          = {cj, cur.row};
            wdata          = cur.value;
            word.addr_byte = {5'd0, cur.row} + 8'd1;
            word.data_byte = cur.value;
            word.last      = jl;
          end
          KIND_REG: begin
            word.addr_byte = {4'd0, cur.reg_address};
            word.data_byte = cur.value;
            word.last      = jl;
          end
          default: begin
            word.addr_byte = {5'd0, ci} + 8'd1;
            word.last      = jl && (ci == LAST_ROW);
          end
        endcase
        if (jl) begin
          cj_next = '0;
          if (cur.kind != KIND_CLEAR || ci == LAST_ROW) begin
            state_next = S_IDLE;
          end else begin
            ci_next = ci + 3'd1;
          end
        end else begin
          cj_next = cj + 3'd1;
        end
      end
      default: begin
        // one entry per cycle, reads for the next entry issued alongside
        wb = (cj == 3'd0) ? d0[7] : wrap;
        if (cj == 3'd0) begin
          wrap_next = d0[7];
        end
        nb = {d0[6:0], (cj == LAST_MOD) ? 1'b0 : d1[7]};
        if (cur.rotate && jl) begin
          nb[0] = wb;
        end
        we    = 1'b1;
        waddr = {cj, ci};
        wdata = nb;
        if (cj <= cur.last_mod) begin
          emit             = 1'b1;
          word.addr_byte   = {5'd0, ci} + 8'd1;
          word.data_byte   = nb;
          word.latch_after = jl;
          word.last        = jl && (ci == LAST_ROW);
        end
        if (cj == LAST_MOD) begin
          cj_next = '0;
          if (ci == LAST_ROW) begin
            state_next = S_IDLE;
          end else begin
            ci_next = ci + 3'd1;
            a0      = {3'd0, ci + 3'd1};
            a1      = {3'd1, ci + 3'd1};
          end
        end else begin
          cj_next = cj + 3'd1;
          a0      = {cj + 3'd1, ci};
          a1      = {cj + 3'd2, ci};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= emit;
    end
    cur      <= cur_next;
    ci       <= ci_next;
    cj       <= cj_next;
    wrap     <= wrap_next;
    dot_byte <= dot_next;
    result   <= word;
  end

endmodule

[verif/tb_top.sv]
// tb_top: self-checking testbench for led_matrix_chain_frame_controller
// depends on lmc_pkg and the rtl; predicts every emitted word from a shadow frame store
// directed command tests, then random traffic over several chain lengths

module tb_top;
  import lmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 68;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  in_t        cmd;
  logic       result_strobe;
  out_t       result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  logic [7:0] shadow_rows [STORE_DEPTH];
  logic [3:0] chain_len;
  out_t       expected_words [$];
  int         word_seq;
  int         err_count;
  int         quiet_cycles;

  led_matrix_chain_frame_controller DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void flag_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  function automatic int active_modules();
    if (chain_len == 4'd0) begin
      return 1;
    end
    if (chain_len > MAX_MODULES) begin
      return MAX_MODULES;
    end
    return int'(chain_len);
  endfunction

  function automatic void queue_word(logic [7:0] addr, logic [7:0] data, bit latch, int total);
    out_t w;
    w.addr_byte   = addr;
    w.data_byte   = data;
    w.latch_after = latch;
    w.last        = (word_seq == total - 1);
    expected_words.push_back(w);
    word_seq++;
  endfunction

  function automatic void predict_words(in_t c);
    int n;
    int i;
    int j;
    logic [5:0] idx;
    logic [7:0] wrap_bits;
    logic [7:0] b;
    n = active_modules();
    word_seq = 0;
    case (c.kind)
      KIND_DOT: begin
        idx = {c.column[5:3], c.row};
        shadow_rows[idx][~c.column[2:0]] = c.value[0];
        for (i = 0; i < n; i++) begin
          if (i == int'(c.column[5:3])) begin
            queue_word({5'd0, c.row} + 8'd1, shadow_rows[idx], i == n - 1, n);
          end else begin
            queue_word(8'h00, 8'h00, i == n - 1, n);
          end
        end
      end
      KIND_ROW: begin
        for (i = 0; i < n; i++) begin
          shadow_rows[i * 8 + int'(c.row)] = c.value;
          queue_word({5'd0, c.row} + 8'd1, c.value, i == n - 1, n);
        end
      end
      KIND_REG: begin
        for (i = 0; i < n; i++) begin
          queue_word({4'd0, c.reg_address}, c.value, i == n - 1, n);
        end
      end
      KIND_SHIFT: begin
        for (i = 0; i < 8; i++) begin
          wrap_bits[i] = shadow_rows[i][7];
        end
        for (i = 0; i < STORE_DEPTH; i++) begin
          b = shadow_rows[i] << 1;
          if (i + 8 < STORE_DEPTH) begin
            b[0] = shadow_rows[i + 8][7];
          end
          shadow_rows[i] = b;
        end
        if (c.rotate) begin
          for (i = 0; i < 8; i++) begin
            shadow_rows[(n - 1) * 8 + i][0] = wrap_bits[i];
          end
        end
        for (i = 0; i < 8; i++) begin
          for (j = 0; j < n; j++) begin
            queue_word(8'(i + 1), shadow_rows[j * 8 + i], j == n - 1, 8 * n);
          end
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < 8; i++) begin
          for (j = 0; j < n; j++) begin
            queue_word(8'(i + 1), 8'h00, j == n - 1, 8 * n);
          end
        end
        for (i = 0; i < STORE_DEPTH; i++) begin
          shadow_rows[i] = 8'h00;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && result_strobe) begin
      if (expected_words.size() == 0) begin
        flag_error($sformatf("unexpected word: addr %02h data %02h latch %0b last %0b",
                             result.addr_byte, result.data_byte, result.latch_after,
                             result.last));
      end else begin
        want = expected_words.pop_front();
        if (result.addr_byte !== want.addr_byte || result.data_byte !== want.data_byte ||
            result.latch_after !== want.latch_after || result.last !== want.last) begin
          flag_error($sformatf({"word mismatch: expected addr %02h data %02h latch %0b ",
                                "last %0b, got addr %02h data %02h latch %0b last %0b"},
                               want.addr_byte, want.data_byte, want.latch_after, want.last,
                               result.addr_byte, result.data_byte, result.latch_after,
                               result.last));
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_command(input in_t c);
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_words(c);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 80);
  endfunction

  task automatic drain_results();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_chain_len(input logic [3:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chain_len = v;
  endtask

  function automatic in_t make_cmd(logic [2:0] kind, logic [5:0] column, logic [2:0] row,
                                   logic [7:0] value, logic [3:0] reg_address, logic rotate);
    in_t c;
    c.kind        = kind;
    c.column      = column;
    c.row         = row;
    c.value       = value;
    c.reg_address = reg_address;
    c.rotate      = rotate;
    return c;
  endfunction

  task automatic send_gapped(input in_t c);
    send_command(c);
    idle_for(pick_gap());
  endtask

  task automatic test_set_dot();
    send_gapped(make_cmd(KIND_DOT, 6'd0, 3'd0, 8'h01, 4'd0, 1'b0));
    send_gapped(make_cmd(KIND_DOT, 6'd63, 3'd7, 8'hFF, 4'hF, 1'b1));
    send_gapped(make_cmd(KIND_DOT, 6'd63, 3'd7, 8'hFE, 4'hF, 1'b1));
  endtask

  task automatic test_row_all();
    send_gapped(make_cmd(KIND_ROW, 6'd0, 3'd7, 8'hFF, 4'd0, 1'b0));
    send_gapped(make_cmd(KIND_ROW, 6'd63, 3'd0, 8'h81, 4'hF, 1'b1));
  endtask

  task automatic test_register_write();
    send_gapped(make_cmd(KIND_REG, 6'd0, 3'd0, 8'hFF, 4'hF, 1'b0));
    send_gapped(make_cmd(KIND_REG, 6'd63, 3'd7, 8'h00, 4'h0, 1'b1));
  endtask

  task automatic test_shift();
    send_gapped(make_cmd(KIND_SHIFT, 6'd0, 3'd0, 8'h00, 4'd0, 1'b1));
    send_gapped(make_cmd(KIND_SHIFT, 6'd63, 3'd7, 8'hFF, 4'hF, 1'b0));
  endtask

  task automatic test_clear();
    send_gapped(make_cmd(KIND_CLEAR, 6'd0, 3'd0, 8'h00, 4'd0, 1'b0));
  endtask

  task automatic test_unknown_kind();
    send_gapped(make_cmd(KIND_SPARE_LO, 6'd5, 3'd2, 8'hFF, 4'hF, 1'b1));
    send_gapped(make_cmd(KIND_SPARE_HI, 6'd63, 3'd7, 8'h55, 4'h3, 1'b0));
    send_gapped(make_cmd(KIND_ROW, 6'd0, 3'd3, 8'h3C, 4'd0, 1'b0));
  endtask

  task automatic test_chain_length_limits();
    write_chain_len(4'd0);
    send_gapped(make_cmd(KIND_DOT, 6'd8, 3'd3, 8'h01, 4'd0, 1'b0));
    send_gapped(make_cmd(KIND_DOT, 6'd0, 3'd2, 8'h01, 4'd0, 1'b0));
    send_gapped(make_cmd(KIND_SHIFT, 6'd0, 3'd0, 8'h00, 4'd0, 1'b1));
    write_chain_len(4'd15);
    send_gapped(make_cmd(KIND_SHIFT, 6'd0, 3'd0, 8'h00, 4'd0, 1'b1));
    send_gapped(make_cmd(KIND_ROW, 6'd0, 3'd5, 8'hA5, 4'd0, 1'b0));
    write_chain_len(4'd3);
    send_gapped(make_cmd(KIND_DOT, 6'd23, 3'd4, 8'h01, 4'd0, 1'b0));
    send_gapped(make_cmd(KIND_DOT, 6'd16, 3'd4, 8'h01, 4'd0, 1'b0));
    send_gapped(make_cmd(KIND_SHIFT, 6'd0, 3'd0, 8'h00, 4'd0, 1'b1));
  endtask

  function automatic in_t random_item(int n);
    in_t c;
    int pick;
    c.column      = 6'($urandom_range(0, 63));
    c.row         = 3'($urandom_range(0, 7));
    c.value       = 8'($urandom_range(0, 255));
    c.reg_address = 4'($urandom_range(0, 15));
    c.rotate      = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c.kind = KIND_DOT;
      if ($urandom_range(0, 3) != 0) begin
        c.column = 6'($urandom_range(0, n * 8 - 1));
      end
    end else if (pick < 55) begin
      c.kind = KIND_ROW;
    end else if (pick < 70) begin
      c.kind = KIND_REG;
    end else if (pick < 85) begin
      c.kind = KIND_SHIFT;
    end else if (pick < 92) begin
      c.kind = KIND_CLEAR;
    end else begin
      c.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    return c;
  endfunction

  task automatic test_random_traffic();
    logic [3:0] lens [6];
    int phase;
    int sent;
    in_t c;
    bit steady;
    lens = '{4'd8, 4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 7)), 4'($urandom_range(0, 15))};
    for (phase = 0; phase < 6; phase++) begin
      write_chain_len(lens[phase]);
      steady = (phase == 2);
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        c = random_item(active_modules());
        send_command(c);
        if (c.kind <= KIND_CLEAR) begin
          sent++;
          if (phase == 4 && sent == RANDOM_PER_PHASE / 2) begin
            drain_results();
          end
        end
        if (!steady) begin
          idle_for(pick_gap());
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    cfg_valid    = 1'b0;
    cfg_data     = 4'd0;
    err_count    = 0;
    quiet_cycles = 0;
    chain_len    = 4'd1;
    foreach (shadow_rows[i]) shadow_rows[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_chain_len(4'd8);
    test_set_dot();
    test_row_all();
    test_register_write();
    test_shift();
    test_clear();
    test_unknown_kind();
    test_chain_length_limits();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[led_matrix_chain_frame_controller.f]
rtl/lmc_pkg.sv
rtl/lmc_front.sv
rtl/lmc_queue.sv
rtl/lmc_back.sv
rtl/led_matrix_chain_frame_controller.sv
verif/tb_top.sv
